// ===== hdl/crcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, constants and the CRC-8 step for the framed serial parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

  // Framing bytes
  localparam logic [7:0] START_FIRST  = 8'hA5;
  localparam logic [7:0] START_SECOND = 8'h5A;
  localparam logic [7:0] CRC_POLY     = 8'h07;

  // Decoded frame kinds
  localparam logic [7:0] ID_BALL  = 8'h10;
  localparam logic [7:0] ID_ROD   = 8'h12;
  localparam logic [5:0] LEN_BALL = 6'd10;
  localparam logic [5:0] LEN_ROD  = 6'd8;

  // Only the first bytes of a payload are ever decoded
  localparam int unsigned STORE_KEEP = 10;

  // Event kinds
  localparam logic [2:0] KIND_GOOD    = 3'd0;
  localparam logic [2:0] KIND_BALL    = 3'd1;
  localparam logic [2:0] KIND_ROD     = 3'd2;
  localparam logic [2:0] KIND_CRC_ERR = 3'd3;
  localparam logic [2:0] KIND_LEN_ERR = 3'd4;

  // Result beat packed width: 139 bits of fields, padded to 144
  localparam int unsigned RES_BITS  = 139;
  localparam int unsigned TDATA_OUT = 144;

  typedef enum logic [2:0] {
    PH_HUNT0 = 3'd0,
    PH_HUNT1 = 3'd1,
    PH_ID    = 3'd2,
    PH_SEQ   = 3'd3,
    PH_LEN   = 3'd4,
    PH_BODY  = 3'd5,
    PH_CHECK = 3'd6
  } phase_t;

  // Declared from the highest field down so that packing puts
  // event_kind in the lowest bits.
  typedef struct packed {
    logic        [31:0] event_count;
    logic        [7:0]  flag_bits;
    logic        [7:0]  confidence;
    logic signed [15:0] value_d;
    logic        [15:0] value_c;
    logic signed [15:0] value_b;
    logic signed [15:0] value_a;
    logic        [7:0]  frame_length;
    logic        [7:0]  sequence_res;
    logic        [7:0]  message_id;
    logic        [2:0]  event_kind;
  } res_t;

  // MSB-first CRC-8, poly 0x07, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] c;
    c = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crcfp_parser.sv =====
// ----------------------------------------------------------------------------
// crcfp_parser
// Frame state machine: start-pair hunt, header, payload capture, CRC check,
// event counters and field decode. One byte per accepted beat.
// ----------------------------------------------------------------------------
module crcfp_parser #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_accept,
  input  logic [7:0]    rx_byte,
  output logic          res_valid,
  output crcfp_pkg::res_t res
);
  import crcfp_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [5:0]  index_r, index_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [31:0] good_cnt_r, good_cnt_nxt;
  logic [31:0] crc_cnt_r, crc_cnt_nxt;
  logic [31:0] len_cnt_r, len_cnt_nxt;
  logic [7:0]  store_r [STORE_KEEP];
  logic [7:0]  crc_upd;

  assign crc_upd = crc8_step(crc_r, rx_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT0;
      id_r       <= '0;
      seq_r      <= '0;
      len_r      <= '0;
      index_r    <= '0;
      crc_r      <= '0;
      good_cnt_r <= '0;
      crc_cnt_r  <= '0;
      len_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      id_r       <= id_nxt;
      seq_r      <= seq_nxt;
      len_r      <= len_nxt;
      index_r    <= index_nxt;
      crc_r      <= crc_nxt;
      good_cnt_r <= good_cnt_nxt;
      crc_cnt_r  <= crc_cnt_nxt;
      len_cnt_r  <= len_cnt_nxt;
    end
  end

  // Payload capture: only the decoded leading bytes are kept
  always_ff @(posedge clk) begin
    if (byte_accept && phase_r == PH_BODY) begin
      for (int i = 0; i < STORE_KEEP; i++) begin
        if (index_r == 6'(i)) begin
          store_r[i] <= rx_byte;
        end
      end
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    id_nxt       = id_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    index_nxt    = index_r;
    crc_nxt      = crc_r;
    good_cnt_nxt = good_cnt_r;
    crc_cnt_nxt  = crc_cnt_r;
    len_cnt_nxt  = len_cnt_r;
    res_valid    = 1'b0;
    res          = '0;
    if (byte_accept) begin
      case (phase_r)
        PH_HUNT0: begin
          if (rx_byte == START_FIRST) begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_HUNT1: begin
          phase_nxt = (rx_byte == START_SECOND) ? PH_ID : PH_HUNT0;
        end
        PH_ID: begin
          id_nxt    = rx_byte;
          crc_nxt   = crc8_step(8'h00, rx_byte);
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          seq_nxt   = rx_byte;
          crc_nxt   = crc_upd;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          index_nxt = '0;
          crc_nxt   = crc_upd;
          if (rx_byte > MaxLen) begin
            len_cnt_nxt      = len_cnt_r + 32'd1;
            res_valid        = 1'b1;
            res.event_kind   = KIND_LEN_ERR;
            res.message_id   = id_r;
            res.sequence_res = seq_r;
            res.frame_length = rx_byte;
            res.event_count  = len_cnt_nxt;
            phase_nxt        = PH_HUNT0;
            id_nxt           = '0;
            seq_nxt          = '0;
            len_nxt          = '0;
            crc_nxt          = '0;
          end else begin
            len_nxt   = rx_byte[5:0];
            phase_nxt = (rx_byte[5:0] == 6'd0) ? PH_CHECK : PH_BODY;
          end
        end
        PH_BODY: begin
          index_nxt = index_r + 6'd1;
          crc_nxt   = crc_upd;
          if (index_nxt >= len_r) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: begin
          res_valid        = 1'b1;
          res.message_id   = id_r;
          res.sequence_res = seq_r;
          res.frame_length = {2'b00, len_r};
          if (rx_byte != crc_r) begin
            crc_cnt_nxt     = crc_cnt_r + 32'd1;
            res.event_kind  = KIND_CRC_ERR;
            res.event_count = crc_cnt_nxt;
          end else begin
            good_cnt_nxt    = good_cnt_r + 32'd1;
            res.event_count = good_cnt_nxt;
            if (id_r == ID_BALL && len_r == LEN_BALL) begin
              res.event_kind = KIND_BALL;
              res.value_a    = {store_r[1], store_r[0]};
              res.value_b    = {store_r[3], store_r[2]};
              res.value_c    = {store_r[5], store_r[4]};
              res.value_d    = {store_r[7], store_r[6]};
              res.confidence = store_r[8];
              res.flag_bits  = store_r[9];
            end else if (id_r == ID_ROD && len_r == LEN_ROD) begin
              res.event_kind = KIND_ROD;
              res.value_a    = {store_r[1], store_r[0]};
              res.value_b    = {store_r[3], store_r[2]};
              res.value_c    = {store_r[5], store_r[4]};
              res.confidence = store_r[6];
              res.flag_bits  = store_r[7];
            end else begin
              res.event_kind = KIND_GOOD;
            end
          end
          phase_nxt = PH_HUNT0;
          id_nxt    = '0;
          seq_nxt   = '0;
          len_nxt   = '0;
          index_nxt = '0;
          crc_nxt   = '0;
        end
        default: begin
          // unused phase code: back to hunting, no event
          phase_nxt = PH_HUNT0;
          id_nxt    = '0;
          seq_nxt   = '0;
          len_nxt   = '0;
          index_nxt = '0;
          crc_nxt   = '0;
        end
      endcase
    end
  end

endmodule

// ===== hdl/crc8_framed_serial_parser.sv =====
// ----------------------------------------------------------------------------
// crc8_framed_serial_parser
// Serial framed packet parser with CRC-8 check and event output.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle while in_tready is high; parser logic
//   runs in the accept cycle. Each event is registered into out_r, or into
//   skid_r while out_* stalls. Output stage is a result register plus one
//   skid register; in_tready drops only while skid_r is occupied.
// Reset (rst_n low, synchronous): parser hunts for 0xA5, all three event
//   counters clear, output and skid registers empty.
// ----------------------------------------------------------------------------
module crc8_framed_serial_parser #(
  parameter int unsigned MAX_PAYLOAD = 32  // largest accepted length, 10..63
) (
  input  logic         clk,
  input  logic         rst_n,
  // input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  // event stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] event_kind, [10:3] message_id, [18:11] sequence_res,
  // [26:19] frame_length, [42:27] value_a, [58:43] value_b,
  // [74:59] value_c, [90:75] value_d, [98:91] confidence,
  // [106:99] flag_bits, [138:107] event_count, [143:139] zero
  output logic [143:0] out_tdata
);
  import crcfp_pkg::*;

  logic byte_accept;
  logic res_valid;
  res_t res;

  // output register and skid register
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic out_take;

  // ready depends only on skid occupancy, never on data
  assign in_tready   = !skid_valid_r;
  assign byte_accept = in_tvalid && in_tready;
  assign out_take    = out_valid_r && out_tready;

  crcfp_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_accept (byte_accept),
    .rx_byte     (in_tdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_comb begin
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (!out_valid_r || out_take) begin
      // output slot free this cycle: skid drains first, keeps order
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = res;
        out_valid_nxt = res_valid;
      end
    end else if (res_valid) begin
      // output stalled: park new event in the skid register
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(TDATA_OUT - RES_BITS)'(0), out_r};

endmodule

// ===== sim/crc8_framed_serial_parser_tb.sv =====
// ----------------------------------------------------------------------------
// crc8_framed_serial_parser_tb
// Self-checking bench for the framed serial parser: feeds byte beats made of
// directed and random frames (decoded ball and rod frames, other good frames,
// CRC and length errors, broken start pairs, cut frames and line noise),
// predicts every event from its own frame tracker and compares each event
// beat field by field, with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module crc8_framed_serial_parser_tb;
  import crcfp_pkg::*;

  localparam int MAX_LEN    = 32;
  localparam int IDLE_LIMIT = 2000;  // cycles without any beat before giving up

  logic         clk;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'h00;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;

  // random gaps on both streams while set
  bit gaps_on = 1'b1;

  // frame tracker state
  phase_t      ph;
  logic [7:0]  hold_id;
  logic [7:0]  hold_seq;
  logic [5:0]  hold_len;
  logic [5:0]  body_idx;
  logic [7:0]  crc_acc;
  logic [7:0]  body_mem [64];
  logic [31:0] cnt_good;
  logic [31:0] cnt_crc;
  logic [31:0] cnt_len;

  res_t        pending_events [$];
  logic [7:0]  frame_body [64];

  int rx_bytes    = 0;
  int events_seen = 0;
  int mismatches  = 0;
  int idle_cycles = 0;
  int kind_hits [5];

  crc8_framed_serial_parser #(
    .MAX_PAYLOAD(MAX_LEN)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // CRC-8, poly 0x07, MSB first, one input bit per step
  function automatic logic [7:0] crc_bitwise(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] r;
    logic       fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ data[i];
      r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return r;
  endfunction

  // drop back to hunting for the first start byte
  function automatic void restart_hunt();
    ph       = PH_HUNT0;
    hold_id  = 8'h00;
    hold_seq = 8'h00;
    hold_len = 6'd0;
    body_idx = 6'd0;
    crc_acc  = 8'h00;
  endfunction

  function automatic void queue_event(input logic [2:0] kind, input logic [7:0] len,
                                      input logic [31:0] count);
    res_t ev;
    ev = '0;
    ev.event_kind   = kind;
    ev.message_id   = hold_id;
    ev.sequence_res = hold_seq;
    ev.frame_length = len;
    ev.event_count  = count;
    // decoded fields, little endian from the payload of this frame
    if (kind == KIND_BALL || kind == KIND_ROD) begin
      ev.value_a = {body_mem[1], body_mem[0]};
      ev.value_b = {body_mem[3], body_mem[2]};
      ev.value_c = {body_mem[5], body_mem[4]};
    end
    if (kind == KIND_BALL) begin
      ev.value_d    = {body_mem[7], body_mem[6]};
      ev.confidence = body_mem[8];
      ev.flag_bits  = body_mem[9];
    end
    if (kind == KIND_ROD) begin
      ev.confidence = body_mem[6];
      ev.flag_bits  = body_mem[7];
    end
    pending_events.push_back(ev);
  endfunction

  // advance the frame tracker by one accepted byte
  function automatic void parse_rx_byte(input logic [7:0] b);
    case (ph)
      PH_HUNT0: begin
        if (b == START_FIRST) ph = PH_HUNT1;
      end
      PH_HUNT1: begin
        // a second 0xA5 here is not a new first start byte
        ph = (b == START_SECOND) ? PH_ID : PH_HUNT0;
      end
      PH_ID: begin
        hold_id = b;
        crc_acc = crc_bitwise(8'h00, b);
        ph      = PH_SEQ;
      end
      PH_SEQ: begin
        hold_seq = b;
        crc_acc  = crc_bitwise(crc_acc, b);
        ph       = PH_LEN;
      end
      PH_LEN: begin
        body_idx = 6'd0;
        crc_acc  = crc_bitwise(crc_acc, b);
        if (int'(b) > MAX_LEN) begin
          cnt_len++;
          queue_event(KIND_LEN_ERR, b, cnt_len);
          restart_hunt();
        end else begin
          hold_len = b[5:0];
          ph       = (hold_len == 6'd0) ? PH_CHECK : PH_BODY;
        end
      end
      PH_BODY: begin
        body_mem[body_idx] = b;
        body_idx = body_idx + 6'd1;
        crc_acc  = crc_bitwise(crc_acc, b);
        if (body_idx >= hold_len) ph = PH_CHECK;
      end
      PH_CHECK: begin
        if (b != crc_acc) begin
          cnt_crc++;
          queue_event(KIND_CRC_ERR, {2'b00, hold_len}, cnt_crc);
        end else begin
          cnt_good++;
          if (hold_id == ID_BALL && hold_len == LEN_BALL) begin
            queue_event(KIND_BALL, {2'b00, hold_len}, cnt_good);
          end else if (hold_id == ID_ROD && hold_len == LEN_ROD) begin
            queue_event(KIND_ROD, {2'b00, hold_len}, cnt_good);
          end else begin
            queue_event(KIND_GOOD, {2'b00, hold_len}, cnt_good);
          end
        end
        restart_hunt();
      end
      default: begin
        restart_hunt();
      end
    endcase
  endfunction

  // one byte beat; returns after the edge that accepted it
  task automatic send_rx_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    parse_rx_byte(b);
    rx_bytes++;
  endtask

  // start pair, header, frame_body[0..len-1] and trailer; a length above the
  // limit ends the frame right after the length byte
  task automatic send_frame(input logic [7:0] id, input logic [7:0] seq,
                            input logic [7:0] len, input bit spoil_crc);
    logic [7:0] c;
    send_rx_byte(START_FIRST);
    send_rx_byte(START_SECOND);
    send_rx_byte(id);
    c = crc_bitwise(8'h00, id);
    send_rx_byte(seq);
    c = crc_bitwise(c, seq);
    send_rx_byte(len);
    c = crc_bitwise(c, len);
    if (int'(len) > MAX_LEN) return;
    for (int n = 0; n < int'(len); n++) begin
      send_rx_byte(frame_body[n]);
      c = crc_bitwise(c, frame_body[n]);
    end
    if (spoil_crc) c = c ^ 8'($urandom_range(1, 255));
    send_rx_byte(c);
  endtask

  task automatic fill_body(input int len);
    for (int n = 0; n < len; n++) frame_body[n] = 8'($urandom_range(0, 255));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  // ball and rod frames with decoded fields at their extremes
  task automatic test_decoded_frames();
    frame_body[0] = 8'h00; frame_body[1] = 8'h80;  // x = -32768
    frame_body[2] = 8'hFF; frame_body[3] = 8'h7F;  // y = 32767
    frame_body[4] = 8'hFF; frame_body[5] = 8'hFF;  // radius 65535
    frame_body[6] = 8'h01; frame_body[7] = 8'h00;
    frame_body[8] = 8'hFF; frame_body[9] = 8'h00;
    send_frame(ID_BALL, 8'h00, 8'(LEN_BALL), 1'b0);
    frame_body[0] = 8'hFF; frame_body[1] = 8'h7F;
    frame_body[2] = 8'h00; frame_body[3] = 8'h80;
    frame_body[4] = 8'h00; frame_body[5] = 8'h00;
    frame_body[6] = 8'h00; frame_body[7] = 8'hFF;
    send_frame(ID_ROD, 8'hFF, 8'(LEN_ROD), 1'b0);
  endtask

  // zero length, oversize lengths and a zero length frame with a bad trailer
  task automatic test_frame_errors();
    send_frame(8'hFF, 8'h5A, 8'd0, 1'b0);
    send_frame(8'h00, 8'hA5, 8'(MAX_LEN + 1), 1'b0);
    send_frame(8'hA5, 8'h00, 8'hFF, 1'b0);
    send_frame(ID_BALL, 8'h7F, 8'd0, 1'b1);
  endtask

  // broken start pairs: the second 0xA5 must not restart the pair
  task automatic test_start_slips();
    send_rx_byte(START_FIRST);
    send_rx_byte(8'h3C);
    send_rx_byte(START_FIRST);
    send_rx_byte(START_FIRST);
    send_rx_byte(START_SECOND);
    send_rx_byte(8'h07);
    fill_body(MAX_LEN);
    send_frame(8'h81, 8'h42, 8'(MAX_LEN), 1'b0);
  endtask

  // mostly well formed frames with random content, plus noise and broken ones
  task automatic test_random_traffic(input int count);
    int stop;
    int pick;
    int len;
    logic [7:0] id;
    stop = rx_bytes + count;
    while (rx_bytes < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        fill_body(int'(LEN_BALL));
        send_frame(ID_BALL, 8'($urandom), 8'(LEN_BALL), $urandom_range(0, 9) == 0);
      end else if (pick < 45) begin
        fill_body(int'(LEN_ROD));
        send_frame(ID_ROD, 8'($urandom), 8'(LEN_ROD), $urandom_range(0, 9) == 0);
      end else if (pick < 60) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(0, 12);
        id  = ($urandom_range(0, 3) == 0) ? ID_BALL + 8'($urandom_range(0, 2)) : 8'($urandom);
        fill_body(len);
        send_frame(id, 8'($urandom), 8'(len), 1'b0);
      end else if (pick < 70) begin
        len = $urandom_range(0, 12);
        fill_body(len);
        send_frame(8'($urandom), 8'($urandom), 8'(len), 1'b1);
      end else if (pick < 78) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom_range(MAX_LEN + 1, 255)), 1'b0);
      end else if (pick < 85) begin
        send_rx_byte(START_FIRST);
        send_rx_byte(8'($urandom));
      end else if (pick < 92) begin
        // cut frame: the next frame's bytes land in its body
        len = $urandom_range(1, 20);
        send_rx_byte(START_FIRST);
        send_rx_byte(START_SECOND);
        send_rx_byte(8'($urandom));
        send_rx_byte(8'($urandom));
        send_rx_byte(8'(len));
        repeat ($urandom_range(0, len - 1)) send_rx_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_rx_byte(8'($urandom));
      end
    end
  endtask

  // sender holds off until every pending event has come out
  task automatic test_sender_hold();
    wait_drain();
    repeat ($urandom_range(2, 6)) @(posedge clk);
  endtask

  // ------------------------------------------------------------ sinks

  // result side backpressure
  always @(posedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(0, 99) >= 23);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("event %0d: %s expected 0x%0h got 0x%0h", events_seen, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_events
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = res_t'(out_tdata[RES_BITS-1:0]);
      events_seen++;
      if (got.event_kind < 3'd5) kind_hits[got.event_kind]++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event %0d: unexpected beat kind %0d id 0x%0h count %0d",
                   events_seen, got.event_kind, got.message_id, got.event_count);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind",   32'(want.event_kind),   32'(got.event_kind));
        check_field("message_id",   32'(want.message_id),   32'(got.message_id));
        check_field("sequence_res", 32'(want.sequence_res), 32'(got.sequence_res));
        check_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
        check_field("value_a",      32'(want.value_a),      32'(got.value_a));
        check_field("value_b",      32'(want.value_b),      32'(got.value_b));
        check_field("value_c",      32'(want.value_c),      32'(got.value_c));
        check_field("value_d",      32'(want.value_d),      32'(got.value_d));
        check_field("confidence",   32'(want.confidence),   32'(got.confidence));
        check_field("flag_bits",    32'(want.flag_bits),    32'(got.flag_bits));
        check_field("event_count",  want.event_count,       got.event_count);
        check_field("pad",          32'd0,             32'(out_tdata[TDATA_OUT-1:RES_BITS]));
      end
    end
  end

  // watchdog: too long without any beat on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d events pending",
                 IDLE_LIMIT, pending_events.size());
        $display("crc8_framed_serial_parser_tb NOT OK");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    restart_hunt();
    cnt_good = '0;
    cnt_crc  = '0;
    cnt_len  = '0;
    foreach (body_mem[i]) body_mem[i] = 8'h00;
    foreach (kind_hits[i]) kind_hits[i] = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_decoded_frames();
    test_frame_errors();
    test_start_slips();
    gaps_on = 1'b0;               // back-to-back stretch on both streams
    test_random_traffic(130);
    test_sender_hold();
    gaps_on = 1'b1;
    test_random_traffic(320);

    wait_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d byte beats, checked %0d events, %0d mismatches", rx_bytes,
             events_seen, mismatches);
    $display("Events: %0d ball, %0d rod, %0d other good, %0d crc error, %0d length error",
             kind_hits[KIND_BALL], kind_hits[KIND_ROD], kind_hits[KIND_GOOD],
             kind_hits[KIND_CRC_ERR], kind_hits[KIND_LEN_ERR]);
    if (mismatches == 0) begin
      $display("crc8_framed_serial_parser_tb OK");
    end else begin
      $display("crc8_framed_serial_parser_tb NOT OK");
    end
    $finish;
  end

endmodule
